FILE: hdl/swm_pkg.sv
// Package for the sliding-window maximum block: sizes, register map and
// the deque entry type. No dependencies; every other file imports it.
package swm_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int ADDR_W     = $clog2(WINDOW_MAX);
    // Positions wrap at twice the window depth; no entry is older than the window.
    localparam int POS_W      = ADDR_W + 1;
    localparam int CNT_W      = ADDR_W + 1;
    localparam int WIN_W      = 7;
    localparam int SAMPLE_W   = 32;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // Register indexes (byte address = 4 * index)
    localparam logic [PADDR_W-3:0] REG_WINDOW_SIZE = '0;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [POS_W-1:0]           pos;
    } entry_t;

endpackage

FILE: hdl/swm_in_if.sv
// Sample channel of the sliding-window maximum block: valid/ready and payload.
// Depends on swm_pkg.
interface swm_in_if
    import swm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first_of_sequence;
    logic                       last_of_sequence;

    modport source (output valid, sample, first_of_sequence, last_of_sequence, input ready);
    modport sink   (input valid, sample, first_of_sequence, last_of_sequence, output ready);
endinterface

FILE: hdl/swm_out_if.sv
// Result channel of the sliding-window maximum block: valid/ready and payload.
// Depends on swm_pkg.
interface swm_out_if
    import swm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] window_max;
    logic                       last_result;

    modport source (output valid, window_max, last_result, input ready);
    modport sink   (input valid, window_max, last_result, output ready);
endinterface

FILE: hdl/sliding_window_max.sv
// Sliding-window maximum over signed 32-bit samples, monotonic deque in a 64-entry RAM.
// Each sample: tail reads and compares pop smaller entries, head reads and compares pop
//   expired ones, then the append; a new sample is taken only once the last is done.
// A waiting result holds the append.
// Reset (rst_n, async, active low): deque empty, counters zero, window_size 1;
//   the RAM is not cleared, only occupied entries are ever read.
module sliding_window_max
    import swm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    swm_in_if.sink                sample_ch,
    swm_out_if.source             result_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_TAIL_RD,
        S_TAIL_CMP,
        S_HEAD_RD,
        S_HEAD_CMP,
        S_APPEND
    } state_t;

    logic [WIN_W-1:0] window;

    swm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .window  (window)
    );

    // Control and datapath registers
    state_t                     state_reg, state_next;
    logic [ADDR_W-1:0]          head_reg, head_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [CNT_W-1:0]           filled_reg, filled_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                       last_reg, last_next;
    logic [WIN_W-1:0]           win_reg, win_next;
    logic signed [SAMPLE_W-1:0] head_val_reg, head_val_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_max_reg, out_max_next;
    logic                       out_last_reg, out_last_next;

    // Deque store: one read and one write port, registered read data
    entry_t            deque_mem [WINDOW_MAX];
    entry_t            rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    logic [ADDR_W-1:0] tail_addr;
    logic [POS_W-1:0]  age;
    logic [CNT_W-1:0]  filled_inc;
    logic              out_free;

    // Last occupied slot and the next free one, both modulo the depth
    assign tail_addr  = head_reg + count_reg[ADDR_W-1:0] - ADDR_W'(1);
    assign wr_addr    = head_reg + count_reg[ADDR_W-1:0];
    assign age        = pos_reg - rd_data_reg.pos;
    assign filled_inc = (filled_reg < CNT_W'(WINDOW_MAX)) ? filled_reg + CNT_W'(1) : filled_reg;
    // The output register can take a new item this cycle
    assign out_free   = !out_valid_reg || result_ch.ready;

    assign sample_ch.ready       = (state_reg == S_IDLE);
    assign result_ch.valid       = out_valid_reg;
    assign result_ch.window_max  = out_max_reg;
    assign result_ch.last_result = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        filled_next    = filled_reg;
        sample_next    = sample_reg;
        last_next      = last_reg;
        win_next       = win_reg;
        head_val_next  = head_val_reg;
        out_valid_next = out_valid_reg;
        out_max_next   = out_max_reg;
        out_last_next  = out_last_reg;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        wr_en          = 1'b0;
        wr_data.value  = sample_reg;
        wr_data.pos    = pos_reg;

        // Drop the result once the sink has taken it
        if (out_valid_reg && result_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    sample_next = sample_ch.sample;
                    last_next   = sample_ch.last_of_sequence;
                    win_next    = window;
                    // A new sequence starts from an empty deque at position zero
                    if (sample_ch.first_of_sequence)
                    begin
                        head_next   = '0;
                        count_next  = '0;
                        pos_next    = '0;
                        filled_next = '0;
                    end
                    state_next = S_TAIL_RD;
                end
            end
            S_TAIL_RD:
            begin
                if (count_reg == '0)
                    state_next = S_HEAD_RD;
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = tail_addr;
                    state_next = S_TAIL_CMP;
                end
            end
            S_TAIL_CMP:
            begin
                // Pop tail entries strictly smaller than the new sample
                if (rd_data_reg.value < sample_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_TAIL_RD;
                end
                else
                    state_next = S_HEAD_RD;
            end
            S_HEAD_RD:
            begin
                if (count_reg == '0)
                    state_next = S_APPEND;
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    state_next = S_HEAD_CMP;
                end
            end
            S_HEAD_CMP:
            begin
                // Pop the head once it has left the window
                if (CNT_W'(age) >= CNT_W'(win_reg))
                begin
                    head_next  = head_reg + ADDR_W'(1);
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    head_val_next = rd_data_reg.value;
                    state_next    = S_APPEND;
                end
            end
            S_APPEND:
            begin
                // Hold here while an earlier result still waits
                if (out_free)
                begin
                    wr_en       = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    pos_next    = pos_reg + POS_W'(1);
                    filled_next = filled_inc;
                    if (filled_inc >= CNT_W'(win_reg))
                    begin
                        out_valid_next = 1'b1;
                        out_max_next   = (count_reg == '0) ? sample_reg : head_val_reg;
                        out_last_next  = last_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            filled_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            filled_reg    <= filled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        last_reg     <= last_next;
        win_reg      <= win_next;
        head_val_reg <= head_val_next;
        out_max_reg  <= out_max_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            deque_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= deque_mem[rd_addr];
    end

    // The deque never holds more than the window depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW_MAX))
        else $error("deque count beyond depth");

    // A stalled result keeps the append waiting
    a_append_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPEND) && out_valid_reg && !result_ch.ready |=> state_reg == S_APPEND)
        else $error("append left while output blocked");

    // A completed append grows the deque by exactly one
    a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPEND) && out_free |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("append did not grow deque");

    // A first-of-sequence item starts from an empty deque at position zero
    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ch.valid && sample_ch.ready && sample_ch.first_of_sequence
        |=> count_reg == '0 && pos_reg == '0 && filled_reg == '0)
        else $error("sequence start did not clear state");

endmodule

FILE: hdl/swm_apb_regs.sv
// APB register file of the sliding-window maximum block: holds window_size
// and hands on the clamped window length. Depends on swm_pkg.
module swm_apb_regs
    import swm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [WIN_W-1:0]      window
);
    logic [WIN_W-1:0] window_size_reg;
    logic             hit;

    assign hit    = (paddr[PADDR_W-1:2] == REG_WINDOW_SIZE);
    assign pready = 1'b1;
    assign prdata = hit ? APB_DATA_W'(window_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WIN_W'(1);
        end
        else if (psel && penable && pwrite && hit)
        begin
            window_size_reg <= pwdata[WIN_W-1:0];
        end
    end

    // Clamp: zero acts as one, anything above the depth as the depth
    always_comb
    begin
        priority if (window_size_reg == '0)
            window = WIN_W'(1);
        else if (window_size_reg > WIN_W'(WINDOW_MAX))
            window = WIN_W'(WINDOW_MAX);
        else
            window = window_size_reg;
    end
endmodule
